// ===== design/assert_macros.svh =====
// Assertion macros included by resolution_id_cam_fifo_evict.
// The first set of definitions applies outside synthesis.
// The second set leaves each macro empty for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check prop at each rising edge of clk while reset is released.
`define RICT_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("rict assertion failed");

// Check that cond never holds at a rising edge of clk while reset is released.
`define RICT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("rict forbidden condition seen");

`else

`define RICT_ASSERT(label, clk, rst_n, prop)
`define RICT_NEVER(label, clk, rst_n, cond)

`endif

`endif

// ===== design/rict_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rict_pkg: shared constants and types for the resolution id table
// Holds the field widths, the default table depth and the cell control word.
// ----------------------------------------------------------------------------
package rict_pkg;

    localparam int KeyW            = 16;
    localparam int SetIdW          = 3;
    localparam int TableEntriesDef = 8;

    // Per-cell update command; load has priority over shift.
    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctrl_t;

endpackage

// ===== design/rict_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rict_cell: one entry of the resolution table
// Stores one width/height pair with its id. It compares the pair against the
// incoming key and loads either the new entry or the data of its upper neighbor.
// ----------------------------------------------------------------------------
module rict_cell #(
    parameter int IdW = 3
) (
    input  logic                       clk,
    input  logic                       valid,
    input  logic [rict_pkg::KeyW-1:0]  key_width,
    input  logic [rict_pkg::KeyW-1:0]  key_height,
    input  logic [IdW-1:0]             new_id,
    input  logic [rict_pkg::KeyW-1:0]  nb_width,
    input  logic [rict_pkg::KeyW-1:0]  nb_height,
    input  logic [IdW-1:0]             nb_id,
    input  rict_pkg::cell_ctrl_t       ctrl,
    output logic [rict_pkg::KeyW-1:0]  width,
    output logic [rict_pkg::KeyW-1:0]  height,
    output logic [IdW-1:0]             id,
    output logic                       hit
);

    logic [rict_pkg::KeyW-1:0] width_reg;
    logic [rict_pkg::KeyW-1:0] height_reg;
    logic [IdW-1:0]            id_reg;

    always_ff @(posedge clk)
    begin
        priority if (ctrl.load)
        begin
            width_reg  <= key_width;
            height_reg <= key_height;
            id_reg     <= new_id;
        end
        else if (ctrl.shift)
        begin
            width_reg  <= nb_width;
            height_reg <= nb_height;
            id_reg     <= nb_id;
        end
    end

    assign hit    = valid && (width_reg == key_width) && (height_reg == key_height);
    assign width  = width_reg;
    assign height = height_reg;
    assign id     = id_reg;

endmodule

// ===== design/resolution_id_cam_fifo_evict.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// resolution_id_cam_fifo_evict: resolution to parameter-set id lookup
// Compares a width/height pair against a chain of table cells. A hit returns
// the stored id; a miss appends the pair, or drops the oldest entry and
// moves every cell down one place when the table is full.
// ----------------------------------------------------------------------------
// Channel   Handshake         Fields
// input     start / busy      pic_width[15:0], pic_height[15:0]
// result    done (strobe)     set_id[2:0], was_known
//
// One word is taken per cycle: busy stays low, so start may be held high.
// The lookup against all cells and the table update both happen at the
// accepting edge; done rises for one cycle right after it.
// Reset clears the fill count, the id counter and the result strobe;
// the cells themselves are not cleared. The receiver cannot stall done.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module resolution_id_cam_fifo_evict #(
    parameter int TABLE_ENTRIES = rict_pkg::TableEntriesDef
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [rict_pkg::KeyW-1:0]    pic_width,
    input  logic [rict_pkg::KeyW-1:0]    pic_height,
    output logic                         done,
    output logic [rict_pkg::SetIdW-1:0]  set_id,
    output logic                         was_known
);

    localparam int IdW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CntW = $clog2(TABLE_ENTRIES + 1);

    logic [CntW-1:0] count_reg,  count_next;
    logic [IdW-1:0]  next_id_reg, next_id_next;
    logic            done_reg;
    logic [rict_pkg::SetIdW-1:0] set_id_reg, set_id_next;
    logic            was_known_reg;

    logic [rict_pkg::KeyW-1:0] cell_width  [TABLE_ENTRIES];
    logic [rict_pkg::KeyW-1:0] cell_height [TABLE_ENTRIES];
    logic [IdW-1:0]            cell_id     [TABLE_ENTRIES];
    logic [rict_pkg::KeyW-1:0] nb_width    [TABLE_ENTRIES];
    logic [rict_pkg::KeyW-1:0] nb_height   [TABLE_ENTRIES];
    logic [IdW-1:0]            nb_id       [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0]  cell_valid;
    logic [TABLE_ENTRIES-1:0]  cell_hit;
    rict_pkg::cell_ctrl_t      cell_ctrl   [TABLE_ENTRIES];

    logic           accept;
    logic           any_hit;
    logic           full;
    logic           miss;
    logic [IdW-1:0] hit_id;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = (count_reg == CntW'(TABLE_ENTRIES));
    assign any_hit = |cell_hit;
    assign miss   = accept && !any_hit;

    genvar g;
    generate
        for (g = 0; g < TABLE_ENTRIES; g++)
        begin : g_cell
            assign cell_valid[g] = (CntW'(g) < count_reg);

            // Each cell takes its upper neighbor; the top cell takes the new word.
            if (g == TABLE_ENTRIES - 1)
            begin : g_top
                assign nb_width[g]  = pic_width;
                assign nb_height[g] = pic_height;
                assign nb_id[g]     = next_id_reg;
            end
            else
            begin : g_mid
                assign nb_width[g]  = cell_width[g+1];
                assign nb_height[g] = cell_height[g+1];
                assign nb_id[g]     = cell_id[g+1];
            end

            assign cell_ctrl[g].shift = miss && full;
            assign cell_ctrl[g].load  = miss && !full && (count_reg == CntW'(g));

            rict_cell #(
                .IdW (IdW)
            ) u_cell (
                .clk        (clk),
                .valid      (cell_valid[g]),
                .key_width  (pic_width),
                .key_height (pic_height),
                .new_id     (next_id_reg),
                .nb_width   (nb_width[g]),
                .nb_height  (nb_height[g]),
                .nb_id      (nb_id[g]),
                .ctrl       (cell_ctrl[g]),
                .width      (cell_width[g]),
                .height     (cell_height[g]),
                .id         (cell_id[g]),
                .hit        (cell_hit[g])
            );
        end
    endgenerate

    // At most one cell matches, so an OR of the masked ids selects it.
    always_comb
    begin
        hit_id = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            hit_id = hit_id | (cell_id[i] & {IdW{cell_hit[i]}});
        end
    end

    always_comb
    begin
        count_next   = count_reg;
        next_id_next = next_id_reg;
        set_id_next  = set_id_reg;
        if (accept)
        begin
            if (any_hit)
            begin
                set_id_next = rict_pkg::SetIdW'(hit_id);
            end
            else
            begin
                set_id_next = rict_pkg::SetIdW'(next_id_reg);
                if (!full)
                begin
                    count_next = count_reg + CntW'(1);
                end
                if (next_id_reg == IdW'(TABLE_ENTRIES - 1))
                begin
                    next_id_next = '0;
                end
                else
                begin
                    next_id_next = next_id_reg + IdW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            next_id_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            next_id_reg <= next_id_next;
            done_reg    <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        set_id_reg <= set_id_next;
        if (accept)
        begin
            was_known_reg <= any_hit;
        end
    end

    assign done      = done_reg;
    assign set_id    = set_id_reg;
    assign was_known = was_known_reg;

    `RICT_ASSERT(a_single_hit, clk, rst_n, $onehot0(cell_hit))
    `RICT_NEVER(a_count_bound, clk, rst_n, count_reg > CntW'(TABLE_ENTRIES))
    `RICT_ASSERT(a_done_follows_start, clk, rst_n, done |-> $past(accept))
    `RICT_ASSERT(a_append_grows, clk, rst_n,
        (miss && !full) |=> (count_reg == $past(count_reg) + CntW'(1)))

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for resolution_id_cam_fifo_evict
// Feeds width/height words through start/busy and tracks the resolution table
// in a local copy. Each done strobe is compared field by field against the
// oldest predicted id and hit flag. Directed words cover hits, partial
// matches, eviction and the field extremes. Random words come from a small
// rotating pool of resolutions so that hits and evictions stay frequent.
// ----------------------------------------------------------------------------
module testbench;

    localparam int KeyW      = rict_pkg::KeyW;
    localparam int SetIdW    = rict_pkg::SetIdW;
    localparam int Depth     = rict_pkg::TableEntriesDef;
    localparam int RandWords = 1350;
    localparam int PoolSize  = 11;
    localparam int Limit     = 200000;

    typedef struct packed {
        logic [KeyW-1:0] w;
        logic [KeyW-1:0] h;
    } res_word_t;

    typedef struct packed {
        logic [SetIdW-1:0] id;
        logic              known;
    } id_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [KeyW-1:0]     pic_width = '0;
    logic [KeyW-1:0]     pic_height = '0;
    logic                done;
    logic [SetIdW-1:0]   set_id;
    logic                was_known;

    res_word_t           pending_words[$];
    id_result_t          due_ids[$];
    int                  err_cnt = 0;
    int                  accepted = 0;
    int                  cycles = 0;

    // local copy of the resolution table
    logic [KeyW-1:0]     tbl_w[Depth];
    logic [KeyW-1:0]     tbl_h[Depth];
    logic [SetIdW-1:0]   tbl_id[Depth];
    int                  tbl_fill = 0;
    int                  id_ctr = 0;

    resolution_id_cam_fifo_evict i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .pic_width    (pic_width),
        .pic_height   (pic_height),
        .done         (done),
        .set_id       (set_id),
        .was_known    (was_known)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Look up the pair; on a miss append it or shift out the oldest entry.
    function automatic id_result_t resolve_set_id(logic [KeyW-1:0] w, logic [KeyW-1:0] h);
        id_result_t r;
        int         slot;
        for (int i = 0; i < tbl_fill; i++)
        begin
            if (tbl_w[i] == w && tbl_h[i] == h)
            begin
                r.id    = tbl_id[i];
                r.known = 1'b1;
                return r;
            end
        end
        if (tbl_fill < Depth)
        begin
            slot     = tbl_fill;
            tbl_fill = tbl_fill + 1;
        end
        else
        begin
            for (int i = 0; i < Depth - 1; i++)
            begin
                tbl_w[i]  = tbl_w[i + 1];
                tbl_h[i]  = tbl_h[i + 1];
                tbl_id[i] = tbl_id[i + 1];
            end
            slot = Depth - 1;
        end
        tbl_w[slot]  = w;
        tbl_h[slot]  = h;
        tbl_id[slot] = id_ctr[SetIdW-1:0];
        id_ctr       = (id_ctr + 1) % Depth;
        r.id    = tbl_id[slot];
        r.known = 1'b0;
        return r;
    endfunction

    // Driver: predict on acceptance, then present the next word or idle.
    always @(posedge clk)
    begin
        res_word_t nxt;
        logic      idle;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                due_ids.push_back(resolve_set_id(pic_width, pic_height));
                accepted = accepted + 1;
            end
            if (start && busy)
            begin
                // hold the word until it is taken
            end
            else
            begin
                idle = (accepted < 400 || accepted >= 800) && ($urandom_range(99) < 9);
                if (pending_words.size() > 0 && !idle)
                begin
                    nxt = pending_words.pop_front();
                    start      <= 1'b1;
                    pic_width  <= nxt.w;
                    pic_height <= nxt.h;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: every done strobe must match the oldest prediction.
    always @(posedge clk)
    begin
        id_result_t exp_r;
        if (rst_n && done === 1'b1)
        begin
            if (due_ids.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual set_id=%0d was_known=%0b",
                         $time, set_id, was_known);
                err_cnt = err_cnt + 1;
            end
            else
            begin
                exp_r = due_ids.pop_front();
                if (set_id !== exp_r.id)
                begin
                    $display("%0t: set_id mismatch: expected %0d, actual %0d",
                             $time, exp_r.id, set_id);
                    err_cnt = err_cnt + 1;
                end
                if (was_known !== exp_r.known)
                begin
                    $display("%0t: was_known mismatch: expected %0b, actual %0b",
                             $time, exp_r.known, was_known);
                    err_cnt = err_cnt + 1;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == Limit)
        begin
            $display("%0t: timeout with %0d results outstanding", $time, due_ids.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        res_word_t wd;
        res_word_t pool[PoolSize];
        for (int k = 0; k < PoolSize; k++)
        begin
            pool[k] = '0;
        end

        // directed: extremes, hits, partial matches, fill and eviction
        pending_words.push_back({16'h0000, 16'h0000});
        pending_words.push_back({16'hFFFF, 16'hFFFF});
        pending_words.push_back({16'h0000, 16'hFFFF});
        pending_words.push_back({16'hFFFF, 16'h0000});
        pending_words.push_back({16'h0000, 16'h0000});
        pending_words.push_back({16'h0280, 16'h01E0});
        pending_words.push_back({16'h0280, 16'h01E1});
        pending_words.push_back({16'h0281, 16'h01E0});
        pending_words.push_back({16'h0780, 16'h0438});
        pending_words.push_back({16'hFFFF, 16'hFFFF});
        pending_words.push_back({16'h0F00, 16'h0870});
        pending_words.push_back({16'h0000, 16'h0000});
        pending_words.push_back({16'hFFFF, 16'hFFFF});
        pending_words.push_back({16'h0F00, 16'h0870});
        pending_words.push_back({16'h0000, 16'h0000});
        pending_words.push_back({16'h0780, 16'h0438});
        pending_words.push_back({16'hAAAA, 16'h5555});
        pending_words.push_back({16'h5555, 16'hAAAA});
        pending_words.push_back({16'hAAAA, 16'h5555});

        // random: mostly pool resolutions, some full-range noise
        for (int n = 0; n < RandWords; n++)
        begin
            if (n % 150 == 0)
            begin
                for (int k = 0; k < PoolSize; k++)
                begin
                    pool[k].h = KeyW'($urandom_range(16'hFFFF));
                    // share a width now and then to force partial matches
                    if (k > 0 && $urandom_range(3) == 0)
                        pool[k].w = pool[k - 1].w;
                    else
                        pool[k].w = KeyW'($urandom_range(16'hFFFF));
                end
            end
            if ($urandom_range(99) < 80)
            begin
                wd = pool[$urandom_range(PoolSize - 1)];
            end
            else
            begin
                wd.w = KeyW'($urandom_range(16'hFFFF));
                wd.h = KeyW'($urandom_range(16'hFFFF));
            end
            pending_words.push_back(wd);
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_words.size() > 0 || start || due_ids.size() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        if (err_cnt == 0 && due_ids.size() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
